// ===== src/brscd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// brscd_pkg: widths, command codes and control/status types of the banked
// register command decoder; no dependencies

package brscd_pkg;

  localparam int unsigned BUFFER_DEPTH = 8192;  // power of two, 256 to 65536
  localparam int unsigned BUF_AW       = $clog2(BUFFER_DEPTH);
  localparam int unsigned PTR_W        = 16;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned RF_DEPTH     = 128;
  localparam int unsigned RF_AW        = $clog2(RF_DEPTH);
  localparam int unsigned ARG_W        = 5;
  localparam int unsigned OPC_W        = 3;

  // opcodes, command bits 7:5
  localparam logic [OPC_W-1:0] OPC_RD_REG = 3'd0;
  localparam logic [OPC_W-1:0] OPC_RD_BUF = 3'd1;
  localparam logic [OPC_W-1:0] OPC_WR_REG = 3'd2;
  localparam logic [OPC_W-1:0] OPC_WR_BUF = 3'd3;
  localparam logic [OPC_W-1:0] OPC_SET    = 3'd4;
  localparam logic [OPC_W-1:0] OPC_CLR    = 3'd5;
  localparam logic [OPC_W-1:0] OPC_SRST   = 3'd7;

  // whole command bytes of the fixed-argument commands
  localparam logic [DATA_W-1:0] CMD_RD_BUF = 8'h3A;
  localparam logic [DATA_W-1:0] CMD_WR_BUF = 8'h7A;
  localparam logic [DATA_W-1:0] CMD_SRST   = 8'hFF;

  // first argument shared by all banks, and the bank select register
  localparam logic [ARG_W-1:0] ARG_COMMON_FIRST = 5'h1B;
  localparam logic [RF_AW-1:0] IDX_BANK         = 7'h1F;

  // controller to datapath strobes
  typedef struct packed {
    logic load;      // capture the accepted item
    logic rd_issue;  // read register file and buffer
    logic exec;      // execute and load the result register
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new item this cycle
  } stat_t;

endpackage

`default_nettype wire

// ===== src/brscd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// brscd_cmd_if and brscd_rsp_if: valid/ready channels for command items and
// result items; depends on brscd_pkg

interface brscd_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [brscd_pkg::DATA_W-1:0]     command;
  logic [brscd_pkg::DATA_W-1:0]     write_data;

  modport source (output valid, output command, output write_data, input ready);
  modport sink   (input valid, input command, input write_data, output ready);
endinterface

interface brscd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [brscd_pkg::DATA_W-1:0]     read_data;
  logic                             read_valid;

  modport source (output valid, output read_data, output read_valid, input ready);
  modport sink   (input valid, input read_data, input read_valid, output ready);
endinterface

`default_nettype wire

// ===== src/brscd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// brscd_ctrl: sequencer for accept, memory read and execute steps
// depends on brscd_pkg

module brscd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_ready_o,
  input  wire brscd_pkg::stat_t stat_i,
  output brscd_pkg::ctrl_t      ctrl_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign accept      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d         = state_q;
    ctrl_o.load     = 1'b0;
    ctrl_o.rd_issue = 1'b0;
    ctrl_o.exec     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        ctrl_o.rd_issue = 1'b1;
        state_d         = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the result register frees up
        if (stat_i.out_free) begin
          ctrl_o.exec = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/brscd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// brscd_dp: register file, buffer memory, pointers and result register
// depends on brscd_pkg

module brscd_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire brscd_pkg::ctrl_t             ctrl_i,
  output brscd_pkg::stat_t                  stat_o,
  input  wire logic [brscd_pkg::DATA_W-1:0] command_i,
  input  wire logic [brscd_pkg::DATA_W-1:0] write_data_i,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i,
  output logic      [brscd_pkg::DATA_W-1:0] read_data_o,
  output logic                              read_valid_o
);

  localparam int unsigned DW = brscd_pkg::DATA_W;

  // captured item
  logic [DW-1:0]                  cmd_q, data_q;
  logic [brscd_pkg::OPC_W-1:0]    opc;
  logic [brscd_pkg::ARG_W-1:0]    arg;

  // pointer bytes (bank 0 entries 0..3) and bank select live in flops
  logic [DW-1:0]                  ptr_q [4];
  logic [DW-1:0]                  bank_q;

  // rest of the register file: memory plus per-entry valid bits
  logic [DW-1:0]                  rf_mem [brscd_pkg::RF_DEPTH];
  logic [brscd_pkg::RF_DEPTH-1:0] rf_vld_q;
  logic [DW-1:0]                  rf_rdata_q;
  logic                           rf_rvld_q;

  logic [DW-1:0]                  buf_mem [brscd_pkg::BUFFER_DEPTH];
  logic [DW-1:0]                  buf_rdata_q;

  logic [brscd_pkg::RF_AW-1:0]    idx;
  logic                           idx_fix;
  logic [DW-1:0]                  old_val, new_val;
  logic [brscd_pkg::PTR_W-1:0]    rd_ptr, wr_ptr;
  logic [brscd_pkg::BUF_AW-1:0]   rd_addr, wr_addr;
  logic [brscd_pkg::PTR_W-1:0]    rd_next, wr_next;
  logic                           is_rd_reg, is_rd_buf, is_wr_buf, is_modify, is_srst;

  logic                           out_valid_q;
  logic [DW-1:0]                  out_data_q, out_data_d;
  logic                           out_rv_q, out_rv_d;

  assign opc = cmd_q[DW-1 -: brscd_pkg::OPC_W];
  assign arg = cmd_q[brscd_pkg::ARG_W-1:0];

  // common registers ignore the bank
  assign idx = (arg >= brscd_pkg::ARG_COMMON_FIRST) ?
               {2'b00, arg} : {bank_q[1:0], arg};
  assign idx_fix = (idx[brscd_pkg::RF_AW-1:2] == '0) || (idx == brscd_pkg::IDX_BANK);

  always_comb begin
    if (idx == brscd_pkg::IDX_BANK) begin
      old_val = bank_q;
    end else if (idx_fix) begin
      old_val = ptr_q[idx[1:0]];
    end else if (rf_rvld_q) begin
      old_val = rf_rdata_q;
    end else begin
      old_val = '0;
    end
  end

  assign is_rd_reg = (opc == brscd_pkg::OPC_RD_REG);
  assign is_rd_buf = (cmd_q == brscd_pkg::CMD_RD_BUF);
  assign is_wr_buf = (cmd_q == brscd_pkg::CMD_WR_BUF);
  assign is_srst   = (cmd_q == brscd_pkg::CMD_SRST);
  assign is_modify = opc inside {brscd_pkg::OPC_WR_REG, brscd_pkg::OPC_SET,
                                 brscd_pkg::OPC_CLR};

  always_comb begin
    case (opc)
      brscd_pkg::OPC_SET: new_val = old_val | data_q;
      brscd_pkg::OPC_CLR: new_val = old_val & ~data_q;
      default:            new_val = data_q;
    endcase
  end

  // pointers wrap at the buffer depth
  assign rd_ptr  = {ptr_q[1], ptr_q[0]};
  assign wr_ptr  = {ptr_q[3], ptr_q[2]};
  assign rd_addr = rd_ptr[brscd_pkg::BUF_AW-1:0];
  assign wr_addr = wr_ptr[brscd_pkg::BUF_AW-1:0];
  assign rd_next = brscd_pkg::PTR_W'(brscd_pkg::BUF_AW'(rd_addr + 1'b1));
  assign wr_next = brscd_pkg::PTR_W'(brscd_pkg::BUF_AW'(wr_addr + 1'b1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= command_i;
      data_q <= write_data_i;
    end
  end

  // register file memory, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_issue) begin
      rf_rdata_q <= rf_mem[idx];
      rf_rvld_q  <= rf_vld_q[idx];
    end
    if (ctrl_i.exec && is_modify && !idx_fix) begin
      rf_mem[idx] <= new_val;
    end
  end

  // buffer memory, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_issue) begin
      buf_rdata_q <= buf_mem[rd_addr];
    end
    if (ctrl_i.exec && is_wr_buf) begin
      buf_mem[wr_addr] <= data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      bank_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        ptr_q[i] <= '0;
      end
    end else if (ctrl_i.exec) begin
      if (is_srst) begin
        rf_vld_q <= '0;
        bank_q   <= '0;
        for (int i = 0; i < 4; i++) begin
          ptr_q[i] <= '0;
        end
      end else if (is_modify) begin
        if (idx == brscd_pkg::IDX_BANK) begin
          bank_q <= new_val;
        end else if (idx_fix) begin
          ptr_q[idx[1:0]] <= new_val;
        end else begin
          rf_vld_q[idx] <= 1'b1;
        end
      end else if (is_rd_buf) begin
        ptr_q[0] <= rd_next[DW-1:0];
        ptr_q[1] <= rd_next[2*DW-1:DW];
      end else if (is_wr_buf) begin
        ptr_q[2] <= wr_next[DW-1:0];
        ptr_q[3] <= wr_next[2*DW-1:DW];
      end
    end
  end

  // result register
  always_comb begin
    out_data_d = '0;
    out_rv_d   = 1'b0;
    if (is_rd_reg) begin
      out_data_d = old_val;
      out_rv_d   = 1'b1;
    end else if (is_rd_buf) begin
      out_data_d = buf_rdata_q;
      out_rv_d   = 1'b1;
    end
  end

  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      out_data_q <= out_data_d;
      out_rv_q   <= out_rv_d;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign read_valid_o = out_rv_q;

endmodule

`default_nettype wire

// ===== src/banked_register_spi_command_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// banked_register_spi_command_decoder_top: command decoder for a banked
// register file and byte buffer; depends on brscd_pkg, brscd_if, brscd_ctrl, brscd_dp
//
// usage
//   cmd_i carries one item per command: command byte (opcode 7:5, argument
//   4:0) and write_data. rsp_o returns exactly one item per command with
//   read_data and read_valid; read_data is zero unless the command was a
//   register read or a buffer read.
//   sequence: an accepted item is captured, its memory read follows, then its
//   execute step loads the result register that drives rsp_o.
//   one item at a time: cmd_i.ready is high only while the sequencer is idle,
//   so a new item is taken only after the last one has executed; the register
//   file and buffer each have one read port whose data is registered before use.
//   stall: the result sits in an output register, so the next item is
//   accepted and read while a result waits; its execute step holds until
//   rsp_o takes the waiting result.
//   reset: register file reads as zero (per-entry valid bits cleared), bank
//   and both buffer pointers are zero; the buffer memory is not cleared and
//   needs no clearing pass. the soft reset command does the same.

module banked_register_spi_command_decoder_top (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  brscd_cmd_if.sink    cmd_i,
  brscd_rsp_if.source  rsp_o
);

  brscd_pkg::ctrl_t ctrl;
  brscd_pkg::stat_t stat;
  logic             cmd_ready;
  logic             rsp_valid;
  logic [brscd_pkg::DATA_W-1:0] read_data;
  logic             read_valid;

  // sequencer: idle -> read -> execute
  brscd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // storage, pointer update and result register
  brscd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .command_i    (cmd_i.command),
    .write_data_i (cmd_i.write_data),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_o.ready),
    .read_data_o  (read_data),
    .read_valid_o (read_valid)
  );

  assign cmd_i.ready      = cmd_ready;
  assign rsp_o.valid      = rsp_valid;
  assign rsp_o.read_data  = read_data;
  assign rsp_o.read_valid = read_valid;

endmodule

`default_nettype wire

// ===== src/brscd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// brscd_checker: port-level checks of the command decoder, bound to the top
// level; depends on brscd_pkg

module brscd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cmd_valid_i,
  input wire logic                         cmd_ready_i,
  input wire logic                         rsp_valid_i,
  input wire logic                         rsp_ready_i,
  input wire logic [brscd_pkg::DATA_W-1:0] read_data_i,
  input wire logic                         read_valid_i
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid_i && cmd_ready_i;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(read_data_i)
      && $stable(read_valid_i))
    else $error("result changed while stalled");

  // non-read results carry zero data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !read_valid_i |-> read_data_i == '0)
    else $error("nonzero data on non-read result");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> !cmd_ready_i)
    else $error("accepted twice in a row");

  // a fresh result rises only after its item's capture, read and execute steps
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(cmd_acc, 3))
    else $error("result without matching item");

endmodule

bind banked_register_spi_command_decoder_top brscd_checker u_brscd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .read_data_i  (rsp_o.read_data),
  .read_valid_i (rsp_o.read_valid)
);

`default_nettype wire
